[hdl/tlru_pkg.sv]
`default_nettype none

package tlru_pkg;

  // Fixed field widths
  localparam int unsigned ADDRESS_W = 24;
  localparam int unsigned TOTAL_W   = 32;

  // Parameter defaults
  localparam int unsigned DEF_NUM_SETS    = 16;
  localparam int unsigned DEF_OFFSET_BITS = 3;
  localparam int unsigned DEF_ADDR_BITS   = 24;

  // Controller states
  typedef enum logic [2:0] {
    ST_CLEAR  = 3'b001,
    ST_IDLE   = 3'b010,
    ST_LOOKUP = 3'b100
  } state_e;

endpackage

`default_nettype wire

[hdl/two_way_lru_cache_tag_store_core.sv]
`default_nettype none

// Tag store of a 2-way set-associative cache with one LRU bit per set.
// Each transaction presents a byte address; the set index sits just above
// the line offset and the tag is every address bit above the index
// (address bits at or above ADDR_BITS are ignored). NUM_SETS must be a
// power of two. All tags, valid bits and LRU bits of one set share one row
// of a single synchronous memory, so a transaction is a read of that row,
// a compare of both ways, and a write back of the updated row. Start is
// taken while busy_o is low, the row read is registered and compared in
// the following cycle, and the result appears with done_o in the cycle
// after that, for exactly one cycle. A new start may be taken in the
// cycle done_o is high, but not in the cycle the row is compared and
// written back. After reset, busy_o stays high while the memory is
// cleared one set per cycle. hit_total_o and miss_total_o hold the
// saturating totals including the access just reported.
module two_way_lru_cache_tag_store_core #(
  parameter int unsigned NUM_SETS    = tlru_pkg::DEF_NUM_SETS,
  parameter int unsigned OFFSET_BITS = tlru_pkg::DEF_OFFSET_BITS,
  parameter int unsigned ADDR_BITS   = tlru_pkg::DEF_ADDR_BITS
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             start_i,
  output logic                                  busy_o,
  input  wire logic [tlru_pkg::ADDRESS_W-1:0]   address_i,
  output logic                                  done_o,
  output logic                                  hit_o,
  output logic                                  way_used_o,
  output logic                                  evicted_o,
  output logic [tlru_pkg::TOTAL_W-1:0]          hit_total_o,
  output logic [tlru_pkg::TOTAL_W-1:0]          miss_total_o
);
  import tlru_pkg::*;

  localparam int unsigned SET_BITS = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
  localparam int unsigned EFF_W    = (ADDR_BITS < ADDRESS_W) ? ADDR_BITS : ADDRESS_W;
  localparam int          TAG_RAW  = int'(EFF_W) - int'(OFFSET_BITS) - int'(SET_BITS);
  localparam int unsigned TAG_W    = (TAG_RAW > 0) ? TAG_RAW : 1;
  localparam logic [ADDRESS_W-1:0] ADDR_MASK = ADDRESS_W'((64'd1 << EFF_W) - 64'd1);
  localparam logic [SET_BITS-1:0]  LAST_SET  = SET_BITS'(NUM_SETS - 1);

  typedef struct packed {
    logic             lru;
    logic             v1;
    logic [TAG_W-1:0] t1;
    logic             v0;
    logic [TAG_W-1:0] t0;
  } row_t;

  state_e               state_q, state_d;
  logic [SET_BITS-1:0]  clr_idx_q;
  logic [SET_BITS-1:0]  set_q;
  logic [TAG_W-1:0]     tag_q;
  row_t                 mem [NUM_SETS];
  row_t                 rd_row_q;
  row_t                 wr_row;
  logic [SET_BITS-1:0]  wr_addr;
  logic                 wr_en;
  logic                 accept;
  logic [ADDRESS_W-1:0] addr_m;
  logic [ADDRESS_W-1:0] line;
  logic                 m0, m1, hit, way, evict;
  logic                 done_q, hit_q, way_q, evict_q;
  logic [TOTAL_W-1:0]   hit_cnt_q, miss_cnt_q;

  assign accept = start_i && (state_q == ST_IDLE);
  assign busy_o = (state_q != ST_IDLE);

  // Split the address into set index and tag
  assign addr_m = address_i & ADDR_MASK;
  assign line   = addr_m >> OFFSET_BITS;

  always_ff @(posedge clk_i) begin
    if (accept) begin
      set_q <= line[SET_BITS-1:0];
      tag_q <= TAG_W'(line >> SET_BITS);
    end
  end

  // Set memory: one read port, one write port, registered read data
  always_ff @(posedge clk_i) begin
    if (accept) begin
      rd_row_q <= mem[line[SET_BITS-1:0]];
    end
    if (wr_en) begin
      mem[wr_addr] <= wr_row;
    end
  end

  // Compare both ways and pick the way to use
  always_comb begin
    m0    = rd_row_q.v0 && (rd_row_q.t0 == tag_q);
    m1    = rd_row_q.v1 && (rd_row_q.t1 == tag_q);
    hit   = m0 || m1;
    evict = 1'b0;
    if (hit) begin
      way = m1;
    end else if (!rd_row_q.v1) begin
      way = 1'b1;
    end else if (!rd_row_q.v0) begin
      way = 1'b0;
    end else begin
      way   = rd_row_q.lru;
      evict = 1'b1;
    end
  end

  // Build the write-back row, or a cleared row during the clearing pass
  always_comb begin
    wr_row  = rd_row_q;
    wr_addr = set_q;
    wr_en   = 1'b0;
    case (state_q)
      ST_CLEAR: begin
        wr_row  = '0;
        wr_addr = clr_idx_q;
        wr_en   = 1'b1;
      end
      ST_LOOKUP: begin
        wr_en      = 1'b1;
        wr_row.lru = ~way;
        if (!hit) begin
          if (way) begin
            wr_row.v1 = 1'b1;
            wr_row.t1 = tag_q;
          end else begin
            wr_row.v0 = 1'b1;
            wr_row.t0 = tag_q;
          end
        end
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  // Advance the controller
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR:  if (clr_idx_q == LAST_SET) state_d = ST_IDLE;
      ST_IDLE:   if (start_i) state_d = ST_LOOKUP;
      ST_LOOKUP: state_d = ST_IDLE;
      default:   state_d = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLEAR;
      clr_idx_q <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_CLEAR) begin
        clr_idx_q <= clr_idx_q + 1'b1;
      end
    end
  end

  // Update saturating totals and the result strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q     <= 1'b0;
      hit_cnt_q  <= '0;
      miss_cnt_q <= '0;
    end else begin
      done_q <= (state_q == ST_LOOKUP);
      if (state_q == ST_LOOKUP) begin
        if (hit) begin
          if (hit_cnt_q != '1) hit_cnt_q <= hit_cnt_q + 1'b1;
        end else begin
          if (miss_cnt_q != '1) miss_cnt_q <= miss_cnt_q + 1'b1;
        end
      end
    end
  end

  // Hold the result fields
  always_ff @(posedge clk_i) begin
    if (state_q == ST_LOOKUP) begin
      hit_q   <= hit;
      way_q   <= way;
      evict_q <= evict;
    end
  end

  assign done_o       = done_q;
  assign hit_o        = hit_q;
  assign way_used_o   = way_q;
  assign evicted_o    = evict_q;
  assign hit_total_o  = hit_cnt_q;
  assign miss_total_o = miss_cnt_q;

  // Checks
  a_done_after_lookup: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(state_q == ST_LOOKUP))
    else $error("result strobe without a lookup");

  a_accept_to_lookup: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == ST_LOOKUP))
    else $error("accepted transaction did not reach lookup");

  a_hit_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_q && hit_q && ($past(hit_cnt_q) != '1)) |->
      (hit_cnt_q == $past(hit_cnt_q) + 1'b1))
    else $error("hit total did not advance on a hit");

  a_evict_on_miss: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_q && evict_q) |-> !hit_q)
    else $error("eviction reported on a hit");

endmodule

`default_nettype wire
